// ===== rtl/pmm_pkg.sv =====
// Package for the sparse polynomial multiplier: widths, limits, state codes.
// Depends on nothing; used by the top level, polynomial_multiply_merge.
package pmm_pkg;
  localparam int MaxTerms = 8;
  localparam int MaxProducts = 64;
  localparam int TermIdxW = $clog2(MaxTerms);
  localparam int TermCntW = $clog2(MaxTerms + 1);
  localparam int ProdIdxW = $clog2(MaxProducts);
  localparam int ProdCntW = $clog2(MaxProducts + 1);
  localparam int CoefW = 16;
  localparam int ExpW = 16;
  localparam int PCoefW = 38;
  localparam int PExpW = 17;
  localparam int TermW = CoefW + ExpW;
  localparam int EntryW = PCoefW + PExpW;

  localparam logic [1:0] FuncLoadFirst = 2'd0;
  localparam logic [1:0] FuncLoadSecond = 2'd1;
  localparam logic [1:0] FuncMultiply = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_TERMS, ST_MUL, ST_SCAN_RD, ST_SCAN, ST_INSERT, ST_SHIFT,
    ST_NEXT, ST_EMIT_RD, ST_EMIT_CHK, ST_FINAL
  } state_t;
endpackage

// ===== rtl/pmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/polynomial_multiply_merge.sv =====
// Top level of the sparse polynomial multiplier: term stores, product table and sequencer.
// Depends on pmm_pkg and pmm_ram.
//
// A multiply request walks every term pair with one shared 16x16 multiplier; each
// product is merged by a scan of the product table and, if its exponent is new,
// inserted in descending order by moving the entries below it down one place; when
// the table is full, a product with a new exponent is dropped. Each scan and shift
// step first reads the table through its single read port. Emission then reads
// the table entry by entry, skips zero sums, and waits when it finds a nonzero term
// while an earlier one is held back and the output register is held. The block is
// not ready while a multiply request is in progress.
module polynomial_multiply_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: coefficient[15:0], exponent[31:16]
  input  logic [31:0] s_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: product_coefficient[37:0], product_exponent[54:38], term_valid[55]
  output logic [55:0] m_tdata,
  output logic        m_tlast
);
  import pmm_pkg::*;

  state_t state, state_next;
  logic [TermCntW-1:0] first_count, second_count;
  logic [TermIdxW-1:0] mi, ni;
  logic [ProdCntW-1:0] pcount;
  logic [ProdCntW-1:0] idx;
  logic [TermW-1:0] fa_rd, sb_rd;
  logic [EntryW-1:0] pt_rd;
  logic signed [CoefW-1:0] fa_c, sb_c;
  logic signed [ExpW-1:0] fa_e, sb_e;
  logic signed [2*CoefW-1:0] mul_c;
  logic signed [PExpW-1:0] sum_e;
  logic signed [PCoefW-1:0] prod_c;
  logic signed [PExpW-1:0] prod_e;
  logic [EntryW-1:0] pending;
  logic [EntryW-1:0] held;
  logic held_valid;
  logic pt_we;
  logic [ProdIdxW-1:0] pt_addr;
  logic [EntryW-1:0] pt_wdata;
  logic out_valid, out_last, out_tv, out_load;
  logic [EntryW-1:0] out_entry;
  logic signed [PExpW-1:0] rd_e;
  logic signed [PCoefW-1:0] rd_c;
  logic acc, load_first, load_second, out_free, last_n, last_m;

  assign acc = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign load_first = acc && (s_tuser == FuncLoadFirst) &&
                      (first_count < TermCntW'(MaxTerms));
  assign load_second = acc && (s_tuser == FuncLoadSecond) &&
                       (second_count < TermCntW'(MaxTerms));
  assign out_free = !out_valid || m_tready;
  assign pt_addr = idx[ProdIdxW-1:0];

  pmm_ram #(.Width(TermW), .Depth(MaxTerms)) u_first (
    .clk, .we(load_first),
    .waddr(first_count[TermIdxW-1:0]), .wdata(s_tdata), .raddr(mi), .rdata(fa_rd));
  pmm_ram #(.Width(TermW), .Depth(MaxTerms)) u_second (
    .clk, .we(load_second),
    .waddr(second_count[TermIdxW-1:0]), .wdata(s_tdata), .raddr(ni), .rdata(sb_rd));
  pmm_ram #(.Width(EntryW), .Depth(MaxProducts)) u_table (
    .clk, .we(pt_we), .waddr(pt_addr), .wdata(pt_wdata), .raddr(pt_addr),
    .rdata(pt_rd));

  assign fa_c = fa_rd[CoefW-1:0];
  assign fa_e = fa_rd[TermW-1:CoefW];
  assign sb_c = sb_rd[CoefW-1:0];
  assign sb_e = sb_rd[TermW-1:CoefW];
  assign mul_c = fa_c * sb_c;
  assign sum_e = fa_e + sb_e;
  assign rd_c = pt_rd[PCoefW-1:0];
  assign rd_e = pt_rd[EntryW-1:PCoefW];
  assign last_n = (TermCntW'(ni) + TermCntW'(1)) == second_count;
  assign last_m = (TermCntW'(mi) + TermCntW'(1)) == first_count;

  always_comb begin
    state_next = state;
    pt_we = 1'b0;
    pt_wdata = pending;
    case (state)
      ST_IDLE: if (acc && s_tuser == FuncMultiply) begin
        state_next = (first_count == '0 || second_count == '0) ? ST_EMIT_RD : ST_RD_TERMS;
      end
      ST_RD_TERMS: state_next = ST_MUL;
      ST_MUL: state_next = ST_SCAN_RD;
      ST_SCAN_RD: state_next = (idx == pcount) ? ST_INSERT : ST_SCAN;
      ST_SCAN: begin
        if (rd_e == prod_e) begin
          pt_we = 1'b1;
          pt_wdata = {rd_e, rd_c + prod_c};
          state_next = ST_NEXT;
        end else if (rd_e < prod_e) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_INSERT: begin
        if (pcount == ProdCntW'(MaxProducts)) begin
          state_next = ST_NEXT;
        end else if (idx == pcount) begin
          pt_we = 1'b1;
          state_next = ST_NEXT;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        pt_we = 1'b1;
        state_next = ST_INSERT;
      end
      ST_NEXT: state_next = (last_n && last_m) ? ST_EMIT_RD : ST_RD_TERMS;
      ST_EMIT_RD: state_next = (idx == pcount) ? ST_FINAL : ST_EMIT_CHK;
      ST_EMIT_CHK: if (rd_c == '0 || !held_valid || out_free) state_next = ST_EMIT_RD;
      ST_FINAL: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first_count <= '0;
      second_count <= '0;
      pcount <= '0;
      idx <= '0;
      mi <= '0;
      ni <= '0;
      held_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (load_first) first_count <= first_count + TermCntW'(1);
          if (load_second) second_count <= second_count + TermCntW'(1);
          mi <= '0;
          ni <= '0;
          pcount <= '0;
          idx <= '0;
          held_valid <= 1'b0;
        end
        ST_MUL: begin
          prod_c <= PCoefW'(mul_c);
          prod_e <= sum_e;
          pending <= {sum_e, PCoefW'(mul_c)};
          idx <= '0;
        end
        ST_SCAN: if (rd_e > prod_e) idx <= idx + ProdCntW'(1);
        ST_INSERT: begin
          if (pcount != ProdCntW'(MaxProducts) && idx == pcount) begin
            pcount <= pcount + ProdCntW'(1);
          end
        end
        ST_SHIFT: begin
          // The entry read here moves one place down on the next write.
          pending <= pt_rd;
          idx <= idx + ProdCntW'(1);
        end
        ST_NEXT: begin
          idx <= '0;
          if (last_n) begin
            ni <= '0;
            mi <= mi + TermIdxW'(1);
          end else begin
            ni <= ni + TermIdxW'(1);
          end
        end
        ST_EMIT_CHK: if (rd_c == '0 || !held_valid || out_free) begin
          idx <= idx + ProdCntW'(1);
          if (rd_c != '0) begin
            held <= pt_rd;
            held_valid <= 1'b1;
          end
        end
        ST_FINAL: if (out_free) begin
          held_valid <= 1'b0;
          first_count <= '0;
          second_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // A nonzero term is held back until the next one is found, so that the last can be marked.
  assign out_load = (state == ST_EMIT_CHK && rd_c != '0 && held_valid && out_free) ||
                    (state == ST_FINAL && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_tv <= 1'b0;
      out_last <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_entry <= (state == ST_FINAL && !held_valid) ? '0 : held;
      out_tv <= !(state == ST_FINAL && !held_valid);
      out_last <= (state == ST_FINAL);
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {out_tv, out_entry};
  assign m_tlast = out_last;
endmodule
